[rtl/frtt_pkg.sv]
// ============================================================================
// frtt_pkg
// Shared widths, register codes, setup states and the interface types of the
// fractional-rate tick timer.
// ============================================================================
package frtt_pkg;

   localparam int TICKS_PER_SECOND_DEFAULT = 32768;
   localparam int PERIOD_WIDTH_DEFAULT     = 16;

   localparam int SECONDS_W  = 32;
   localparam int FRAC_W     = 16;
   localparam int SUB_W      = 15;
   localparam int STAMP_W    = 32;
   localparam int ERR_W      = 16;
   localparam int RATE_W     = 16;
   localparam int POR_W      = 17;
   localparam int DIV_STEPS  = 16;
   localparam int STEP_CNT_W = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_PERIOD_OR_RATE = 2'd0,
      REG_RATE_MODE      = 2'd1,
      REG_START_SECONDS  = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      SETUP_IDLE,
      SETUP_LOAD,
      SETUP_DIV,
      SETUP_FINISH
   } setup_state_type;

   typedef struct packed {
      logic              enable;
      logic [RATE_W-1:0] rate_value;
      logic [ERR_W-1:0]  error_step;
   } timing_type;

   typedef struct packed {
      logic                 period_event;
      logic [SECONDS_W-1:0] epoch_seconds;
      logic [SUB_W-1:0]     sub_second;
      logic [STAMP_W-1:0]   tick_stamp;
   } result_type;

endpackage

[rtl/frtt_setup.sv]
// ============================================================================
// frtt_setup
// Derives the period lengths and error step from the configuration with a
// restoring divider, one quotient bit per cycle.
// ============================================================================
module frtt_setup #(
   parameter int TICKS_PER_SECOND = frtt_pkg::TICKS_PER_SECOND_DEFAULT,
   parameter int PERIOD_WIDTH     = frtt_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [frtt_pkg::POR_W-1:0]  period_or_rate,
   input  logic                        rate_mode,
   output logic                        busy,
   output frtt_pkg::timing_type        timing,
   output logic [PERIOD_WIDTH:0]       len_short,
   output logic [PERIOD_WIDTH:0]       len_long
);
   import frtt_pkg::*;

   localparam int LEN_W = PERIOD_WIDTH + 1;
   localparam int CMP_W = (LEN_W > POR_W + 1) ? LEN_W : POR_W + 1;
   localparam logic [CMP_W-1:0] PERIOD_CAP = {{(CMP_W-1){1'b0}}, 1'b1} << PERIOD_WIDTH;
   localparam logic [RATE_W-1:0] TR_VALUE = RATE_W'(TICKS_PER_SECOND);
   localparam logic [POR_W-1:0] TR_POR = POR_W'(TICKS_PER_SECOND);

   setup_state_type        state_ff, state_in;
   logic [STEP_CNT_W-1:0]  count_ff, count_in;
   logic [RATE_W-1:0]      dvd_ff, dvd_in;
   logic [RATE_W-1:0]      rem_ff, rem_in;
   logic [RATE_W-1:0]      quo_ff, quo_in;
   logic [RATE_W-1:0]      div_ff, div_in;
   timing_type             timing_ff, timing_in;
   logic [LEN_W-1:0]       len_short_ff, len_short_in;
   logic [LEN_W-1:0]       len_long_ff, len_long_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SETUP_IDLE;
         count_ff     <= '0;
         timing_ff    <= '0;
         len_short_ff <= '0;
         len_long_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         timing_ff    <= timing_in;
         len_short_ff <= len_short_in;
         len_long_ff  <= len_long_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   always_comb begin
      logic [RATE_W:0]    rem_shift;
      logic [RATE_W:0]    diff;
      logic [POR_W-1:0]   short_period;
      logic [CMP_W-1:0]   s_ext;
      logic [CMP_W-1:0]   l_ext;

      state_in     = state_ff;
      count_in     = count_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      timing_in    = timing_ff;
      len_short_in = len_short_ff;
      len_long_in  = len_long_ff;

      rem_shift = {rem_ff, dvd_ff[RATE_W-1]};
      diff      = rem_shift - {1'b0, div_ff};

      if (rate_mode && period_or_rate != '0) begin
         short_period = {{(POR_W-RATE_W){1'b0}}, quo_ff};
      end else begin
         short_period = period_or_rate;
      end
      s_ext = CMP_W'(short_period);
      l_ext = s_ext + CMP_W'(1);

      case (state_ff)
         SETUP_IDLE: begin
         end
         SETUP_LOAD: begin
            div_in   = (period_or_rate > TR_POR) ? TR_VALUE : period_or_rate[RATE_W-1:0];
            dvd_in   = TR_VALUE;
            rem_in   = '0;
            quo_in   = '0;
            count_in = STEP_CNT_W'(DIV_STEPS - 1);
            state_in = SETUP_DIV;
         end
         SETUP_DIV: begin
            if (!diff[RATE_W]) begin
               rem_in = diff[RATE_W-1:0];
            end else begin
               rem_in = rem_shift[RATE_W-1:0];
            end
            quo_in   = {quo_ff[RATE_W-2:0], ~diff[RATE_W]};
            dvd_in   = {dvd_ff[RATE_W-2:0], 1'b0};
            count_in = count_ff - STEP_CNT_W'(1);
            if (count_ff == '0) begin
               state_in = SETUP_FINISH;
            end
         end
         SETUP_FINISH: begin
            timing_in.enable = (period_or_rate != '0);
            if (rate_mode && period_or_rate != '0) begin
               timing_in.rate_value = div_ff;
               timing_in.error_step = rem_ff;
            end else begin
               timing_in.rate_value = '0;
               timing_in.error_step = '0;
            end
            len_short_in = LEN_W'((s_ext > PERIOD_CAP) ? PERIOD_CAP : s_ext);
            len_long_in  = LEN_W'((l_ext > PERIOD_CAP) ? PERIOD_CAP : l_ext);
            state_in     = SETUP_IDLE;
         end
         default: begin
            state_in = SETUP_IDLE;
         end
      endcase

      if (go) begin
         timing_in.enable = 1'b0;
         state_in         = SETUP_LOAD;
      end
   end

   assign busy      = (state_ff != SETUP_IDLE);
   assign timing    = timing_ff;
   assign len_short = len_short_ff;
   assign len_long  = len_long_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SETUP_FINISH && div_ff != '0) |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

   a_enable_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(timing_ff.enable) |-> $past(state_ff == SETUP_FINISH))
      else $error("timer enabled without a finished setup");

   a_enable_lengths: assert property (@(posedge clock) disable iff (reset)
      timing_ff.enable |-> (len_short_ff != '0 && len_long_ff >= len_short_ff))
      else $error("enabled timer with bad period lengths");

endmodule

[rtl/frtt_tick.sv]
// ============================================================================
// frtt_tick
// Per-tick state: period counter with error accumulator, seconds and
// sub-second ticks, and the result of the tick being processed.
// ============================================================================
module frtt_tick #(
   parameter int TICKS_PER_SECOND = frtt_pkg::TICKS_PER_SECOND_DEFAULT,
   parameter int PERIOD_WIDTH     = frtt_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            second_mark,
   input  logic                            restart,
   input  logic                            load_seconds,
   input  logic [frtt_pkg::SECONDS_W-1:0]  load_value,
   input  frtt_pkg::timing_type            timing,
   input  logic [PERIOD_WIDTH:0]           len_short,
   input  logic [PERIOD_WIDTH:0]           len_long,
   output frtt_pkg::result_type            result
);
   import frtt_pkg::*;

   localparam int LEN_W = PERIOD_WIDTH + 1;
   localparam logic [FRAC_W-1:0]    TR_FRAC  = FRAC_W'(TICKS_PER_SECOND);
   localparam logic [FRAC_W-1:0]    TR_MAX   = FRAC_W'(TICKS_PER_SECOND - 1);
   localparam logic [STAMP_W-1:0]   TR_STAMP = STAMP_W'(TICKS_PER_SECOND);

   logic [PERIOD_WIDTH-1:0] period_count_ff, period_count_in;
   logic                    long_next_ff, long_next_in;
   logic [ERR_W-1:0]        error_sum_ff, error_sum_in;
   logic [SECONDS_W-1:0]    seconds_ff, seconds_in;
   logic [FRAC_W-1:0]       fraction_ff, fraction_in;

   logic [LEN_W-1:0]        cnt_inc;
   logic [LEN_W-1:0]        len_sel;
   logic                    fire;
   logic [ERR_W-1:0]        esum;
   logic                    wrap;
   logic [FRAC_W-1:0]       sub_clamp;
   logic [FRAC_W-1:0]       sub_sat;
   logic                    carry;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= '0;
         long_next_ff    <= 1'b0;
         error_sum_ff    <= '0;
         seconds_ff      <= '0;
         fraction_ff     <= '0;
      end else begin
         period_count_ff <= period_count_in;
         long_next_ff    <= long_next_in;
         error_sum_ff    <= error_sum_in;
         seconds_ff      <= seconds_in;
         fraction_ff     <= fraction_in;
      end
   end

   assign cnt_inc = LEN_W'(period_count_ff) + LEN_W'(1);
   assign len_sel = long_next_ff ? len_long : len_short;
   assign fire    = timing.enable && (cnt_inc >= len_sel);
   assign esum    = error_sum_ff + timing.error_step;
   assign wrap    = (timing.rate_value != '0) && (esum >= timing.rate_value);

   always_comb begin
      period_count_in = period_count_ff;
      long_next_in    = long_next_ff;
      error_sum_in    = error_sum_ff;
      seconds_in      = seconds_ff;
      fraction_in     = fraction_ff;

      if (step) begin
         if (timing.enable) begin
            period_count_in = fire ? '0 : cnt_inc[PERIOD_WIDTH-1:0];
         end
         if (fire) begin
            error_sum_in = wrap ? esum - timing.rate_value : esum;
            long_next_in = wrap && (timing.error_step != '0);
         end
         if (second_mark) begin
            seconds_in  = seconds_ff + SECONDS_W'(1);
            fraction_in = '0;
         end else begin
            fraction_in = fraction_ff + FRAC_W'(1);
         end
      end

      if (restart) begin
         period_count_in = '0;
         long_next_in    = 1'b0;
         error_sum_in    = '0;
      end
      if (load_seconds) begin
         seconds_in  = load_value;
         fraction_in = '0;
      end
   end

   // clamp the sub-second count below the tick rate
   assign carry     = (fraction_in >= TR_FRAC);
   assign sub_clamp = carry ? fraction_in - TR_FRAC : fraction_in;
   assign sub_sat   = (sub_clamp >= TR_FRAC) ? TR_MAX : sub_clamp;

   assign result.period_event  = fire;
   assign result.epoch_seconds = seconds_in + SECONDS_W'(carry);
   assign result.sub_second    = sub_sat[SUB_W-1:0];
   assign result.tick_stamp    = seconds_in * TR_STAMP + STAMP_W'(fraction_in);

   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      timing.enable |-> LEN_W'(period_count_ff) < len_sel)
      else $error("period counter past period length");

   a_error_below_rate: assert property (@(posedge clock) disable iff (reset)
      (timing.enable && timing.rate_value != '0) |-> error_sum_ff < timing.rate_value)
      else $error("error accumulator not below rate");

   a_long_needs_step: assert property (@(posedge clock) disable iff (reset)
      long_next_ff |-> timing.error_step != '0)
      else $error("long period without error step");

endmodule

[rtl/fractional_rate_tick_timer.sv]
// ============================================================================
// fractional_rate_tick_timer
// Tick timer with fractional-rate period events, epoch seconds, sub-second
// ticks and a 32-bit tick timestamp, one result word per tick word.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_second_mark
//   rsp      out        rsp_valid / rsp_stall  rsp_period_event, rsp_epoch_seconds,
//                                              rsp_sub_second, rsp_tick_stamp
//   csr      in/out     psel / penable / pready  paddr, pwdata, prdata
//
// One tick word per cycle unless req_stall is high; each word passes an input
// register and then a result register.
// A write to period_or_rate or rate_mode runs the setup divider (one quotient
// bit per cycle); req_stall is high meanwhile.
// Reset clears all counters and disables period events.
// rsp_stall holds the result register; the input register takes one more word.
// ============================================================================
module fractional_rate_tick_timer #(
   parameter int TICKS_PER_SECOND = frtt_pkg::TICKS_PER_SECOND_DEFAULT,
   parameter int PERIOD_WIDTH     = frtt_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_second_mark,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_period_event,
   output logic [frtt_pkg::SECONDS_W-1:0]   rsp_epoch_seconds,
   output logic [frtt_pkg::SUB_W-1:0]       rsp_sub_second,
   output logic [frtt_pkg::STAMP_W-1:0]     rsp_tick_stamp,

   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [frtt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [frtt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [frtt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import frtt_pkg::*;

   logic [POR_W-1:0]      por_ff, por_in;
   logic                  mode_ff, mode_in;
   logic [SECONDS_W-1:0]  start_ff, start_in;
   logic                  in_valid_ff, in_valid_in;
   logic                  in_mark_ff, in_mark_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff, out_in;

   csr_reg_type           reg_sel;
   logic                  wr;
   logic                  setup_go;
   logic                  load_seconds;
   logic                  setup_busy;
   logic                  out_free;
   logic                  accept;
   logic                  step;
   timing_type            timing;
   logic [PERIOD_WIDTH:0] len_short;
   logic [PERIOD_WIDTH:0] len_long;
   result_type            result;

   assign pready       = 1'b1;
   assign reg_sel      = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr           = psel && penable && pwrite && pready;
   assign setup_go     = wr && (reg_sel == REG_PERIOD_OR_RATE || reg_sel == REG_RATE_MODE);
   assign load_seconds = wr && (reg_sel == REG_START_SECONDS);

   always_comb begin
      por_in   = por_ff;
      mode_in  = mode_ff;
      start_in = start_ff;
      prdata   = '0;
      if (wr) begin
         case (reg_sel)
            REG_PERIOD_OR_RATE: por_in   = pwdata[POR_W-1:0];
            REG_RATE_MODE:      mode_in  = pwdata[0];
            REG_START_SECONDS:  start_in = pwdata[SECONDS_W-1:0];
            default: begin
            end
         endcase
      end
      case (reg_sel)
         REG_PERIOD_OR_RATE: prdata = CSR_DATA_W'(por_ff);
         REG_RATE_MODE:      prdata = CSR_DATA_W'(mode_ff);
         REG_START_SECONDS:  prdata = CSR_DATA_W'(start_ff);
         default:            prdata = '0;
      endcase
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = setup_busy || (in_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;
   assign step      = in_valid_ff && out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_mark_in   = in_mark_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_mark_in  = req_second_mark;
      end else if (out_free) begin
         in_valid_in = 1'b0;
      end
      if (step) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         por_ff       <= '0;
         mode_ff      <= 1'b0;
         start_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         por_ff       <= por_in;
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_mark_ff <= in_mark_in;
      out_ff     <= out_in;
   end

   frtt_setup #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .PERIOD_WIDTH     (PERIOD_WIDTH)
   ) u_setup (
      .clock          (clock),
      .reset          (reset),
      .go             (setup_go),
      .period_or_rate (por_ff),
      .rate_mode      (mode_ff),
      .busy           (setup_busy),
      .timing         (timing),
      .len_short      (len_short),
      .len_long       (len_long)
   );

   frtt_tick #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .PERIOD_WIDTH     (PERIOD_WIDTH)
   ) u_tick (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .second_mark  (in_mark_ff),
      .restart      (setup_go),
      .load_seconds (load_seconds),
      .load_value   (pwdata[SECONDS_W-1:0]),
      .timing       (timing),
      .len_short    (len_short),
      .len_long     (len_long),
      .result       (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_period_event  = out_ff.period_event;
   assign rsp_epoch_seconds = out_ff.epoch_seconds;
   assign rsp_sub_second    = out_ff.sub_second;
   assign rsp_tick_stamp    = out_ff.tick_stamp;

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed word did not reach the result register");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      setup_busy |-> !accept)
      else $error("word accepted during timer setup");

   a_stalled_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("input register dropped a word under stall");

endmodule
